[rtl/pbts_pkg.sv]
`default_nettype none

package pbts_pkg;

    typedef enum logic [3:0] {
        OP_INIT      = 4'd0,
        OP_ACTIVATE  = 4'd1,
        OP_WAIT      = 4'd2,
        OP_WAKE      = 4'd3,
        OP_DELAY     = 4'd4,
        OP_TICK      = 4'd5,
        OP_EXIT      = 4'd6,
        OP_SELECT    = 4'd7,
        OP_INT_ENTER = 4'd8,
        OP_INT_LEAVE = 4'd9
    } pbts_op_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_OBJ_ERROR  = 2'd1;
    localparam logic [1:0] ST_PARAM_ERROR = 2'd2;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_READY_MAP = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DISPATCH_DISABLED = 1'd1;

    localparam logic [15:0] NEST_MAX = 16'hFFFF;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [2:0]  task_index;
        logic [31:0] delay_ticks;
    } pbts_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       dispatch_request;
        logic [2:0] next_task;
        logic       idle;
        logic [7:0] ready_map;
        logic       reschedule_pending;
    } pbts_out_t;

endpackage

`default_nettype wire

[rtl/priority_bitmap_task_scheduler.sv]
`default_nettype none

// Priority-bitmap task scheduler. Each kernel call (init, activate, wait, wake, delay, tick,
// exit, select, interrupt enter and leave) is one input beat and yields exactly one result
// beat. A beat is first captured in an input register; when the result register is free or
// being read, the whole operation, including the parallel timeout decrementers and the
// find-first-set over the ready map, is evaluated and written into the scheduler state and
// the result register at the same clock edge. One beat is accepted every cycle while the
// result side keeps up. The configuration registers are written through cfg_we, cfg_index
// and cfg_data and should only change while the block is idle.
module priority_bitmap_task_scheduler #(
    parameter int NUM_TASKS    = 8,
    parameter int TIMEOUT_BITS = 32
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  pbts_pkg::pbts_in_t                   in_data,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output pbts_pkg::pbts_out_t                  out_data,
    input  wire                                  cfg_we,
    input  wire  [pbts_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [pbts_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import pbts_pkg::*;

    localparam int TIDX = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam logic [32:0] MAX_DELAY = (33'd1 << TIMEOUT_BITS) - 33'd2;

    function automatic logic [TIDX-1:0] first_set(input logic [NUM_TASKS-1:0] map);
        logic [TIDX-1:0] result;
        result = '0;
        for (int i = NUM_TASKS - 1; i >= 0; i--)
        begin
            if (map[i])
            begin
                result = TIDX'(i);
            end
        end
        return result;
    endfunction

    // Configuration
    logic [7:0] cfg_map_reg;
    logic       cfg_dis_reg;

    // Pipeline
    logic      s1_valid_reg;
    pbts_in_t  s1_data_reg;
    logic      out_valid_reg;
    pbts_out_t out_data_reg;
    pbts_out_t out_data_next;
    logic      s1_advance;

    // Scheduler state
    logic [NUM_TASKS-1:0]    ready_reg, ready_next;
    logic [NUM_TASKS-1:0]    waiting_reg, waiting_next;
    logic [TIMEOUT_BITS-1:0] tout_reg  [NUM_TASKS];
    logic [TIMEOUT_BITS-1:0] tout_next [NUM_TASKS];
    logic                    run_valid_reg, run_valid_next;
    logic [TIDX-1:0]         run_idx_reg, run_idx_next;
    logic                    last_valid_reg, last_valid_next;
    logic [TIDX-1:0]         last_idx_reg, last_idx_next;
    logic                    resched_reg, resched_next;
    logic [15:0]             nest_reg, nest_next;

    logic                    task_ok;
    logic [TIDX-1:0]         tidx;
    logic                    to_dispatcher;
    logic [1:0]              status;
    logic                    req;
    logic [TIDX-1:0]         next_idx;
    logic                    idle;
    logic [TIMEOUT_BITS-1:0] armed_delay;
    logic [TIDX-1:0]         top_ready;
    logic                    delay_too_long;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_map_reg <= '0;
            cfg_dis_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INITIAL_READY_MAP: cfg_map_reg <= cfg_data;
                CFG_DISPATCH_DISABLED: cfg_dis_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg      <= '0;
            waiting_reg    <= '0;
            run_valid_reg  <= 1'b0;
            run_idx_reg    <= '0;
            last_valid_reg <= 1'b0;
            last_idx_reg   <= '0;
            resched_reg    <= 1'b0;
            nest_reg       <= '0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                tout_reg[i] <= '0;
            end
        end
        else if (s1_advance)
        begin
            ready_reg      <= ready_next;
            waiting_reg    <= waiting_next;
            run_valid_reg  <= run_valid_next;
            run_idx_reg    <= run_idx_next;
            last_valid_reg <= last_valid_next;
            last_idx_reg   <= last_idx_next;
            resched_reg    <= resched_next;
            nest_reg       <= nest_next;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                tout_reg[i] <= tout_next[i];
            end
        end
    end

    assign task_ok        = 32'(s1_data_reg.task_index) < NUM_TASKS;
    assign tidx           = TIDX'(s1_data_reg.task_index);
    assign armed_delay    = s1_data_reg.delay_ticks[TIMEOUT_BITS-1:0] + TIMEOUT_BITS'(1);
    assign top_ready      = first_set(ready_reg);
    assign delay_too_long = {1'b0, s1_data_reg.delay_ticks} > MAX_DELAY;

    always_comb
    begin
        ready_next      = ready_reg;
        waiting_next    = waiting_reg;
        run_valid_next  = run_valid_reg;
        run_idx_next    = run_idx_reg;
        last_valid_next = last_valid_reg;
        last_idx_next   = last_idx_reg;
        resched_next    = resched_reg;
        nest_next       = nest_reg;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            tout_next[i] = tout_reg[i];
        end
        to_dispatcher = 1'b0;
        status        = ST_OK;
        req           = 1'b0;
        next_idx      = '0;
        idle          = 1'b0;

        case (s1_data_reg.opcode)
            OP_INIT:
            begin
                ready_next      = NUM_TASKS'(cfg_map_reg);
                waiting_next    = '0;
                run_valid_next  = 1'b0;
                run_idx_next    = '0;
                last_valid_next = 1'b0;
                for (int i = 0; i < NUM_TASKS; i++)
                begin
                    tout_next[i] = '0;
                end
            end
            OP_ACTIVATE:
            begin
                if (!task_ok)
                begin
                    status = ST_PARAM_ERROR;
                end
                else
                begin
                    ready_next[tidx] = 1'b1;
                    // With no task running, any task outranks it.
                    if ((!run_valid_reg || tidx < run_idx_reg) && !cfg_dis_reg)
                    begin
                        req      = 1'b1;
                        next_idx = tidx;
                    end
                end
            end
            OP_WAIT, OP_DELAY:
            begin
                if ((s1_data_reg.opcode == OP_DELAY) && delay_too_long)
                begin
                    status = ST_PARAM_ERROR;
                end
                else if (!run_valid_reg)
                begin
                    status = ST_OBJ_ERROR;
                end
                else
                begin
                    waiting_next[run_idx_reg] = 1'b1;
                    ready_next[run_idx_reg]   = 1'b0;
                    if (s1_data_reg.opcode == OP_DELAY)
                    begin
                        tout_next[run_idx_reg] = armed_delay;
                    end
                    to_dispatcher = 1'b1;
                end
            end
            OP_WAKE:
            begin
                if (!task_ok)
                begin
                    status = ST_PARAM_ERROR;
                end
                else if (!waiting_reg[tidx])
                begin
                    status = ST_OBJ_ERROR;
                end
                else
                begin
                    waiting_next[tidx] = 1'b0;
                    ready_next[tidx]   = 1'b1;
                    to_dispatcher      = 1'b1;
                end
            end
            OP_TICK:
            begin
                for (int i = 0; i < NUM_TASKS; i++)
                begin
                    if (tout_reg[i] != '0)
                    begin
                        tout_next[i] = tout_reg[i] - TIMEOUT_BITS'(1);
                        if (tout_reg[i] == TIMEOUT_BITS'(1))
                        begin
                            waiting_next[i] = 1'b0;
                            ready_next[i]   = 1'b1;
                            resched_next    = 1'b1;
                        end
                    end
                end
            end
            OP_EXIT:
            begin
                if (!run_valid_reg)
                begin
                    status = ST_OBJ_ERROR;
                end
                else
                begin
                    ready_next[run_idx_reg] = 1'b0;
                    to_dispatcher           = 1'b1;
                end
            end
            OP_SELECT:
            begin
                if (ready_reg == '0)
                begin
                    last_valid_next = 1'b0;
                    idle            = 1'b1;
                end
                else
                begin
                    next_idx        = top_ready;
                    run_valid_next  = 1'b1;
                    run_idx_next    = top_ready;
                    last_valid_next = 1'b1;
                    last_idx_next   = top_ready;
                    req             = 1'b1;
                end
            end
            OP_INT_ENTER:
            begin
                if (nest_reg != NEST_MAX)
                begin
                    nest_next = nest_reg + 16'd1;
                end
            end
            OP_INT_LEAVE:
            begin
                if (nest_reg != '0)
                begin
                    nest_next = nest_reg - 16'd1;
                end
                // The outermost leave with a pending reschedule may switch tasks.
                if ((nest_next == '0) && resched_reg)
                begin
                    resched_next = 1'b0;
                    if (ready_reg != '0)
                    begin
                        next_idx = top_ready;
                        if (last_valid_reg && (last_idx_reg != top_ready))
                        begin
                            run_valid_next  = 1'b1;
                            run_idx_next    = top_ready;
                            last_valid_next = 1'b1;
                            last_idx_next   = top_ready;
                            req             = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                status = ST_PARAM_ERROR;
            end
        endcase

        if (to_dispatcher && (ready_next != '0))
        begin
            req      = 1'b1;
            next_idx = first_set(ready_next);
        end

        out_data_next.status             = status;
        out_data_next.dispatch_request   = req;
        out_data_next.next_task          = 3'(next_idx);
        out_data_next.idle               = idle;
        out_data_next.ready_map          = 8'(ready_next);
        out_data_next.reschedule_pending = resched_next;
    end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import pbts_pkg::*;

    localparam int          NUM_TASKS    = 8;
    localparam logic [3:0]  RUN_NONE     = 4'd8;
    localparam logic [3:0]  IDLE_MARK    = 4'hF;
    localparam logic [31:0] MAX_DELAY    = 32'hFFFF_FFFE;
    localparam logic [3:0]  OP_UNUSED_LO = 4'd10;
    localparam logic [3:0]  OP_UNUSED_HI = 4'd15;
    localparam int          PHASES       = 8;
    localparam int          PHASE_CALLS  = 250;
    localparam int          CYCLE_LIMIT  = 1_500_000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    pbts_in_t                    in_data;
    logic                        out_valid;
    logic                        out_ready;
    pbts_out_t                   out_data;
    logic                        cfg_we;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;

    // When calm is set the receiver never stalls.
    logic calm = 1'b0;
    int   cycles = 0;
    int   settings_used = 0;

    class sched_scoreboard;
        logic [7:0]  ready_bits;
        logic [7:0]  waiting_bits;
        logic [31:0] timeouts [NUM_TASKS];
        logic [3:0]  running;
        logic [3:0]  last_run;
        logic        resched;
        logic [15:0] nest;
        logic [7:0]  boot_map;
        logic        no_dispatch;
        pbts_out_t   expected_q [$];
        int          op_count [16];
        int          checked;
        int          errors;

        function new();
            boot_map     = '0;
            no_dispatch  = 1'b0;
            ready_bits   = '0;
            waiting_bits = '0;
            foreach (timeouts[i]) timeouts[i] = '0;
            running      = RUN_NONE;
            last_run     = IDLE_MARK;
            resched      = 1'b0;
            nest         = '0;
            foreach (op_count[i]) op_count[i] = 0;
            checked      = 0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [7:0] val);
            if (idx == CFG_INITIAL_READY_MAP)
                boot_map = val;
            else if (idx == CFG_DISPATCH_DISABLED)
                no_dispatch = val[0];
        endfunction

        function logic [2:0] first_ready();
            logic [2:0] pick;
            pick = 3'd0;
            for (int i = NUM_TASKS - 1; i >= 0; i--)
                if (ready_bits[i]) pick = i[2:0];
            return pick;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_call(pbts_in_t it);
            pbts_out_t  res;
            logic       to_disp;
            logic [2:0] cur;
            res     = '0;
            to_disp = 1'b0;
            cur     = running[2:0];
            op_count[it.opcode]++;
            case (it.opcode)
                OP_INIT: begin
                    ready_bits   = boot_map;
                    waiting_bits = '0;
                    foreach (timeouts[i]) timeouts[i] = '0;
                    running      = RUN_NONE;
                    last_run     = IDLE_MARK;
                end
                OP_ACTIVATE: begin
                    ready_bits[it.task_index] = 1'b1;
                    if ({1'b0, it.task_index} < running && !no_dispatch) begin
                        res.dispatch_request = 1'b1;
                        res.next_task        = it.task_index;
                    end
                end
                OP_WAIT, OP_DELAY: begin
                    if (it.opcode == OP_DELAY && it.delay_ticks > MAX_DELAY)
                        res.status = ST_PARAM_ERROR;
                    else if (running >= NUM_TASKS)
                        res.status = ST_OBJ_ERROR;
                    else begin
                        waiting_bits[cur] = 1'b1;
                        ready_bits[cur]   = 1'b0;
                        if (it.opcode == OP_DELAY)
                            timeouts[cur] = it.delay_ticks + 32'd1;
                        to_disp = 1'b1;
                    end
                end
                OP_WAKE: begin
                    if (!waiting_bits[it.task_index])
                        res.status = ST_OBJ_ERROR;
                    else begin
                        waiting_bits[it.task_index] = 1'b0;
                        ready_bits[it.task_index]   = 1'b1;
                        to_disp = 1'b1;
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < NUM_TASKS; i++) begin
                        if (timeouts[i] != 0) begin
                            timeouts[i] = timeouts[i] - 32'd1;
                            if (timeouts[i] == 0) begin
                                waiting_bits[i] = 1'b0;
                                ready_bits[i]   = 1'b1;
                                resched         = 1'b1;
                            end
                        end
                    end
                end
                OP_EXIT: begin
                    if (running >= NUM_TASKS)
                        res.status = ST_OBJ_ERROR;
                    else begin
                        ready_bits[cur] = 1'b0;
                        to_disp = 1'b1;
                    end
                end
                OP_SELECT: begin
                    if (ready_bits == 0) begin
                        last_run = IDLE_MARK;
                        res.idle = 1'b1;
                    end else begin
                        res.next_task        = first_ready();
                        running              = {1'b0, res.next_task};
                        last_run             = running;
                        res.dispatch_request = 1'b1;
                    end
                end
                OP_INT_ENTER: begin
                    if (nest != NEST_MAX) nest++;
                end
                OP_INT_LEAVE: begin
                    if (nest != 0) nest--;
                    if (nest == 0 && resched) begin
                        resched = 1'b0;
                        if (ready_bits != 0) begin
                            cur           = first_ready();
                            res.next_task = cur;
                            // The outermost leave only switches away from a real,
                            // different task.
                            if (last_run != IDLE_MARK && last_run != {1'b0, cur}) begin
                                running              = {1'b0, cur};
                                last_run             = running;
                                res.dispatch_request = 1'b1;
                            end
                        end
                    end
                end
                default: res.status = ST_PARAM_ERROR;
            endcase
            if (to_disp && ready_bits != 0) begin
                res.dispatch_request = 1'b1;
                res.next_task        = first_ready();
            end
            res.ready_map          = ready_bits;
            res.reschedule_pending = resched;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(pbts_out_t got);
            pbts_out_t want;
            if (expected_q.size() == 0) begin
                $error("result beat %h arrived with no call outstanding", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("dispatch_request", 8'(want.dispatch_request),
                          8'(got.dispatch_request));
            compare_field("next_task", 8'(want.next_task), 8'(got.next_task));
            compare_field("idle", 8'(want.idle), 8'(got.idle));
            compare_field("ready_map", want.ready_map, got.ready_map);
            compare_field("reschedule_pending", 8'(want.reschedule_pending),
                          8'(got.reschedule_pending));
        endfunction
    endclass

    sched_scoreboard sb;

    priority_bitmap_task_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(30, 1)) @(posedge clk);
            if (!calm && $urandom_range(1, 0) == 1)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(15, 1)) @(posedge clk);
            end
        end
    end

    // Valid stays high from one beat to the next unless a pause or a drain lowers it.
    task automatic send(input pbts_in_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_call(it);
    endtask

    task automatic call(input logic [3:0] op, input logic [2:0] idx, input logic [31:0] d);
        pbts_in_t it;
        it.opcode      = op;
        it.task_index  = idx;
        it.delay_ticks = d;
        send(it);
    endtask

    task automatic pause_sender(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [7:0] map_v, input logic dis_v);
        write_reg(CFG_INITIAL_READY_MAP, map_v);
        write_reg(CFG_DISPATCH_DISABLED, {7'd0, dis_v});
        settings_used++;
    endtask

    // Mostly calls that keep a task running and timers expiring, with some noise.
    function automatic pbts_in_t random_call();
        pbts_in_t it;
        int       r;
        int       pick;
        it.task_index  = 3'($urandom_range(7, 0));
        it.delay_ticks = $urandom();
        it.opcode      = OP_SELECT;
        r = $urandom_range(99, 0);
        if (r < 12)
            it.opcode = OP_SELECT;
        else if (r < 24)
            it.opcode = OP_ACTIVATE;
        else if (r < 31)
            it.opcode = OP_WAIT;
        else if (r < 39)
        begin
            it.opcode = OP_WAKE;
            if (sb.waiting_bits != 0 && $urandom_range(4, 0) != 0)
            begin
                do pick = $urandom_range(7, 0); while (!sb.waiting_bits[pick]);
                it.task_index = 3'(pick);
            end
        end
        else if (r < 49)
        begin
            it.opcode = OP_DELAY;
            case ($urandom_range(9, 0))
                0: it.delay_ticks = $urandom();
                1: it.delay_ticks = $urandom_range(1, 0) ? MAX_DELAY : ~32'd0;
                default: it.delay_ticks = $urandom_range(6, 0);
            endcase
        end
        else if (r < 66)
            it.opcode = OP_TICK;
        else if (r < 71)
            it.opcode = OP_EXIT;
        else if (r < 79)
            it.opcode = OP_INT_ENTER;
        else if (r < 91)
            it.opcode = OP_INT_LEAVE;
        else if (r < 95)
            it.opcode = OP_INIT;
        else
            it.opcode = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        return it;
    endfunction

    initial
    begin
        logic [7:0] maps [PHASES];
        logic       gaps_on;
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full map with dispatching enabled.
        set_regs(8'hFF, 1'b0);
        call(OP_INIT, 3'd0, 32'd0);
        call(OP_SELECT, 3'd0, 32'd0);
        call(OP_ACTIVATE, 3'd7, 32'd0);
        call(OP_WAIT, 3'd0, 32'd0);
        call(OP_WAKE, 3'd0, 32'd0);
        call(OP_WAKE, 3'd0, 32'd0);
        call(OP_DELAY, 3'd0, ~32'd0);
        call(OP_DELAY, 3'd0, MAX_DELAY);
        call(OP_SELECT, 3'd0, 32'd0);
        call(OP_DELAY, 3'd0, 32'd0);
        call(OP_TICK, 3'd0, 32'd0);
        call(OP_INT_ENTER, 3'd0, 32'd0);
        call(OP_INT_ENTER, 3'd0, 32'd0);
        call(OP_INT_LEAVE, 3'd0, 32'd0);
        call(OP_INT_LEAVE, 3'd0, 32'd0);
        call(OP_INT_LEAVE, 3'd0, 32'd0);
        call(OP_EXIT, 3'd0, 32'd0);
        call(OP_UNUSED_HI, 3'd7, ~32'd0);
        call(OP_UNUSED_LO, 3'd0, 32'd0);

        // Directed: empty map, dispatching disabled, no task running.
        drain();
        set_regs(8'h00, 1'b1);
        call(OP_INIT, 3'd0, 32'd0);
        call(OP_SELECT, 3'd0, 32'd0);
        call(OP_WAIT, 3'd0, 32'd0);
        call(OP_EXIT, 3'd0, 32'd0);
        call(OP_DELAY, 3'd0, 32'd3);
        call(OP_ACTIVATE, 3'd5, 32'd0);

        maps[0] = 8'h00;
        maps[1] = 8'hFF;
        maps[2] = 8'($urandom_range(255, 0));
        maps[3] = 8'h80;
        maps[4] = 8'($urandom_range(255, 0));
        maps[5] = 8'h01;
        maps[6] = 8'($urandom_range(255, 0));
        maps[7] = 8'hFF;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            set_regs(maps[ph], ph % 3 == 1);
            calm    = (ph == 2 || ph == PHASES - 1);
            gaps_on = !calm;
            call(OP_INIT, 3'd0, 32'd0);
            for (int n = 0; n < PHASE_CALLS; n++)
            begin
                send(random_call());
                if (ph == 1 && n == PHASE_CALLS / 2)
                    drain();
                else if (gaps_on && $urandom_range(4, 0) == 0)
                    pause_sender($urandom_range(15, 1));
            end
        end

        // Nesting count driven three levels deep, then unwound with more leaves than enters; it stays at zero.
        drain();
        calm = 1'b1;
        repeat (3) call(OP_INT_ENTER, 3'd0, 32'd0);
        call(OP_TICK, 3'd0, 32'd0);
        repeat (5) call(OP_INT_LEAVE, 3'd0, 32'd0);

        drain();
        repeat (8) @(posedge clk);
        $display("Ran %0d register settings: %0d selects, %0d ticks, %0d delays, %0d wakes.",
                 settings_used, sb.op_count[OP_SELECT], sb.op_count[OP_TICK],
                 sb.op_count[OP_DELAY], sb.op_count[OP_WAKE]);
        $display("Checked %0d result beats, nesting unwound past zero; %0d errors.",
                 sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/pbts_pkg.sv
rtl/priority_bitmap_task_scheduler.sv
tb/tb.sv
